[sv/fem_pkg.sv]
package fem_pkg;

  localparam int unsigned MaxSamples = 65536;
  localparam int unsigned CntW = 17;
  localparam logic [CntW-1:0] CNT_MAX = CntW'(MaxSamples);
  localparam logic [63:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [22:0] PCT_Q16 = 23'd6553600;
  localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

  typedef enum logic [1:0] {
    MODE_MAE  = 2'd0,
    MODE_MSE  = 2'd1,
    MODE_RMSE = 2'd2,
    MODE_MAPE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_FLOOR = 2'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TDIV,
    ST_ADD,
    ST_FIN,
    ST_FDIV,
    ST_SQRT,
    ST_EMIT
  } back_st_t;

  typedef struct packed {
    logic signed [31:0] actual_value;
    logic signed [31:0] forecast_value;
    logic               last_sample;
  } in_req_t;

  typedef struct packed {
    logic [62:0]     metric_value;
    logic [CntW-1:0] counted_samples;
    logic            sum_saturated;
  } out_rsp_t;

  typedef struct packed {
    logic [32:0] abs_e;
    logic [31:0] abs_a;
    mode_t       mode;
    logic        counts;
    logic        last;
  } item_t;

endpackage

[sv/fem_front.sv]
module fem_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [30:0]       cfg_data,
  input  fem_pkg::in_req_t  in_req,
  output fem_pkg::item_t    item
);

  fem_pkg::mode_t mode_r, mode_nxt;
  logic [30:0]    floor_r, floor_nxt;
  logic signed [32:0] diff;

  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt  = mode_r;
    floor_nxt = floor_r;
    if (cfg_valid) begin
      unique case (fem_pkg::reg_idx_t'(cfg_index))
        fem_pkg::REG_MODE:  mode_nxt  = fem_pkg::mode_t'(cfg_data[1:0]);
        fem_pkg::REG_FLOOR: floor_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= fem_pkg::MODE_MAE;
      floor_r <= 31'd1;
    end else begin
      mode_r  <= mode_nxt;
      floor_r <= floor_nxt;
    end
  end

  assign diff = 33'(in_req.actual_value) - 33'(in_req.forecast_value);

  always_comb begin
    item.abs_e  = diff[32] ? 33'(-diff) : 33'(diff);
    item.abs_a  = in_req.actual_value[31] ? 32'(-in_req.actual_value)
                                          : 32'(in_req.actual_value);
    item.mode   = mode_r;
    item.counts = item.abs_a > {1'b0, floor_r};
    item.last   = in_req.last_sample;
  end

endmodule

[sv/fem_queue.sv]
module fem_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fem_pkg::item_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output fem_pkg::item_t rdata
);

  fem_pkg::item_t ent_r [2];
  logic       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign rdata   = ent_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? !wr_r : wr_r;
    rd_nxt  = do_pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_r] <= wdata;
    end
  end

endmodule

[sv/fem_div.sv]
module fem_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [63:0] quot
);

  logic [31:0] rem_r, rem_nxt, dvs_r;
  logic [63:0] quo_r, quo_nxt;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] rem_sh;

  assign busy   = busy_r;
  assign done   = done_r;
  assign quot   = quo_r;
  assign rem_sh = {rem_r, quo_r[63]};

  always_comb begin
    if (rem_sh >= {1'b0, dvs_r}) begin
      rem_nxt = 32'(rem_sh - {1'b0, dvs_r});
      quo_nxt = {quo_r[62:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[31:0];
      quo_nxt = {quo_r[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule

[sv/fem_back.sv]
module fem_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  fem_pkg::item_t    q_item,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output fem_pkg::out_rsp_t out_rsp
);

  fem_pkg::back_st_t st_r, st_nxt;
  fem_pkg::item_t    it_r;
  fem_pkg::out_rsp_t rsp_r;
  logic        rsp_vld_r;
  logic [63:0] prod_r, acc_r, term, mean_r;
  logic [64:0] sum;
  logic [16:0] samp_r, vld_r, cnt_sel;
  logic        ovf_r;
  logic [63:0] sq_v_r, sq_root_r, sq_bit_r, sq_rb;
  logic [4:0]  sq_cnt_r;
  logic        div_start, div_busy, div_done;
  logic [63:0] div_dvd, div_quot;
  logic [31:0] div_dvs;
  logic        slot_free, emit;

  assign slot_free = !rsp_vld_r || out_pop;
  assign out_empty = !rsp_vld_r;
  assign out_rsp   = rsp_r;
  assign cnt_sel   = (it_r.mode == fem_pkg::MODE_MAPE) ? vld_r : samp_r;
  assign sq_rb     = sq_root_r + sq_bit_r;

  always_comb begin
    if (it_r.mode == fem_pkg::MODE_MAPE) begin
      term = it_r.counts ? div_quot : 64'd0;
    end else begin
      term = prod_r;
    end
    sum = {1'b0, acc_r} + {1'b0, term};
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      fem_pkg::ST_IDLE: if (!q_empty) st_nxt = fem_pkg::ST_MUL;
      fem_pkg::ST_MUL:
        st_nxt = (it_r.mode == fem_pkg::MODE_MAPE && it_r.counts) ? fem_pkg::ST_TDIV
                                                                 : fem_pkg::ST_ADD;
      fem_pkg::ST_TDIV: if (div_done) st_nxt = fem_pkg::ST_ADD;
      fem_pkg::ST_ADD:  st_nxt = it_r.last ? fem_pkg::ST_FIN : fem_pkg::ST_IDLE;
      fem_pkg::ST_FIN:  st_nxt = fem_pkg::ST_FDIV;
      fem_pkg::ST_FDIV:
        if (div_done) begin
          st_nxt = (it_r.mode == fem_pkg::MODE_RMSE) ? fem_pkg::ST_SQRT : fem_pkg::ST_EMIT;
        end
      fem_pkg::ST_SQRT: if (sq_cnt_r == 5'd31) st_nxt = fem_pkg::ST_EMIT;
      fem_pkg::ST_EMIT: if (slot_free) st_nxt = fem_pkg::ST_IDLE;
      default: st_nxt = fem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_dvd   = acc_r;
    div_dvs   = {15'd0, (cnt_sel == 17'd0) ? 17'd1 : cnt_sel};
    emit      = 1'b0;
    unique case (st_r)
      fem_pkg::ST_IDLE: q_pop = !q_empty;
      fem_pkg::ST_MUL: begin
        div_start = it_r.mode == fem_pkg::MODE_MAPE && it_r.counts;
        div_dvd   = 64'(it_r.abs_e) * 64'(fem_pkg::PCT_Q16);
        div_dvs   = it_r.abs_a;
      end
      fem_pkg::ST_FIN:  div_start = 1'b1;
      fem_pkg::ST_EMIT: emit = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= fem_pkg::ST_IDLE;
      rsp_vld_r <= 1'b0;
      acc_r     <= '0;
      samp_r    <= '0;
      vld_r     <= '0;
      ovf_r     <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit) begin
        rsp_vld_r <= 1'b1;
      end else if (out_pop) begin
        rsp_vld_r <= 1'b0;
      end
      if (st_r == fem_pkg::ST_ADD) begin
        if (sum > {1'b0, fem_pkg::ACC_MAX}) begin
          acc_r <= fem_pkg::ACC_MAX;
          ovf_r <= 1'b1;
        end else begin
          acc_r <= sum[63:0];
        end
        if (samp_r != fem_pkg::CNT_MAX) samp_r <= samp_r + 17'd1;
        if (it_r.mode == fem_pkg::MODE_MAPE && it_r.counts && vld_r != fem_pkg::CNT_MAX) begin
          vld_r <= vld_r + 17'd1;
        end
      end else if (emit) begin
        acc_r  <= '0;
        samp_r <= '0;
        vld_r  <= '0;
        ovf_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) it_r <= q_item;
    if (st_r == fem_pkg::ST_MUL) begin
      if (it_r.mode == fem_pkg::MODE_MAE) begin
        prod_r <= 64'(it_r.abs_e);
      end else begin
        prod_r <= 64'(it_r.abs_e) * 64'(it_r.abs_e);
      end
    end
    if (st_r == fem_pkg::ST_FDIV && div_done) begin
      mean_r    <= div_quot;
      sq_v_r    <= div_quot;
      sq_root_r <= '0;
      sq_bit_r  <= fem_pkg::SQRT_BIT0;
      sq_cnt_r  <= '0;
    end else if (st_r == fem_pkg::ST_SQRT) begin
      if (sq_v_r >= sq_rb) begin
        sq_v_r    <= sq_v_r - sq_rb;
        sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
      end else begin
        sq_root_r <= sq_root_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
      sq_cnt_r <= sq_cnt_r + 5'd1;
    end
    if (emit) begin
      rsp_r.metric_value    <= (it_r.mode == fem_pkg::MODE_RMSE) ? sq_root_r[62:0]
                                                                 : mean_r[62:0];
      rsp_r.counted_samples <= cnt_sel;
      rsp_r.sum_saturated   <= ovf_r;
    end
  end

  fem_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot)
  );

`ifndef SYNTH
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_acc_cap: assert property (@(posedge clk) disable iff (!rst_n) !acc_r[63])
    else $error("accumulator above cap");
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    samp_r <= fem_pkg::CNT_MAX && vld_r <= samp_r)
    else $error("count bound broken");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n) emit |=> rsp_vld_r && samp_r == 17'd0)
    else $error("emit did not load result");
`endif

endmodule

[sv/forecast_error_metric.sv]
// Forecast error measure (MAE, MSE, RMSE, MAPE) over a series of sample pairs.
// Input queue side: drive in_req and raise in_push while in_full is low; each
// request is one actual/forecast pair, in_req.last_sample closes the series.
// Result queue side: while out_empty is low, out_rsp holds the mean of the
// closed series (its square root in RMSE mode); raise out_pop to take it.
// Config: cfg_index 0 selects the mode, 1 the percentage floor; cfg_ready is
// always high. Write only while no series is in flight.
// Back end: a pair runs IDLE, MUL, ADD; in percentage mode a pair above the
// floor also waits in TDIV on the 64-step shared divider. A closing pair then
// runs FIN, FDIV (mean division), SQRT (square root, RMSE mode) and EMIT.
// The back end sequencer takes a new pair only once the last is through; a
// 2-entry queue decouples it from the input side.
// Reset: mode 0, floor 1, sums and counts cleared, both queues empty.
// A stalled receiver holds the result; the back end then waits to emit the
// next one and the input side fills and raises in_full.
module forecast_error_metric (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  fem_pkg::in_req_t  in_req,
  output logic              out_empty,
  input  logic              out_pop,
  output fem_pkg::out_rsp_t out_rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [30:0]       cfg_data
);

  fem_pkg::item_t f_item, q_item;
  logic q_empty, q_pop;

  fem_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_req),
    .item      (f_item)
  );

  fem_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (f_item),
    .full  (in_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_item)
  );

  fem_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_rsp   (out_rsp)
  );

endmodule
